>>> hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked property with reset disable
`define I2A_ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2a assertion failed");

// antecedent holds, consequent holds in the next cycle
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  `I2A_ASSERT_PROP(label, clk, rst_n, (ante) |=> (cons))

`endif

>>> hdl/i2a_pkg.sv
// Types and constants of the integer to ASCII formatter
package i2a_pkg;

  localparam int unsigned VAL_W          = 32;
  localparam int unsigned NUM_DEC_DIGITS = 10;
  localparam int unsigned BCD_W          = 4 * NUM_DEC_DIGITS;
  localparam int unsigned DABBLE_STEPS   = VAL_W;
  localparam int unsigned STEP_W         = $clog2(DABBLE_STEPS);
  localparam int unsigned REM_W          = $clog2(VAL_W + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A_LC  = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  typedef enum logic [2:0] {
    REQ_LITERAL  = 3'd0,
    REQ_SIGNED   = 3'd1,
    REQ_UNSIGNED = 3'd2,
    REQ_HEX      = 3'd3,
    REQ_BINARY   = 3'd4
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_CONV,
    ST_TRIM,
    ST_EMIT
  } i2a_state_e;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] value;
  } i2a_cmd_t;

  typedef struct packed {
    logic busy;
  } i2a_sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CHAR_ZERO + {4'b0, nib};
    end else begin
      ch = CHAR_A_LC + {4'b0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

>>> hdl/i2a_dabble.sv
// Shift-and-add-3 binary to BCD converter, one bit per cycle
module i2a_dabble (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  i2a_pkg::i2a_cmd_t          cmd_i,
  output i2a_pkg::i2a_sts_t          sts_o,
  output logic [i2a_pkg::BCD_W-1:0]  bcd_o
);
  import i2a_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DABBLE_STEPS - 1);

  logic [VAL_W-1:0]  bin_q, bin_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [BCD_W-1:0]  bcd_adj;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;

  always_comb begin
    for (int i = 0; i < NUM_DEC_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    step_d = step_q;
    busy_d = busy_q;
    if (cmd_i.start) begin
      bin_d  = cmd_i.value;
      bcd_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      {bcd_d, bin_d} = {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
      step_d         = step_q + 1'b1;
      busy_d         = (step_q != STEP_LAST);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign sts_o.busy = busy_q;
  assign bcd_o      = bcd_q;

endmodule

>>> hdl/integer_to_ascii_formatter_top.sv
// Integer to ASCII formatter, top level
// One request at a time; in_stall_o is high from acceptance until the last
// character has been loaded into the output register. Characters leave at up
// to one per cycle while the output is not stalled: literal 1, hex 8, binary
// 32 characters. Decimal requests first run the shared BCD converter, which
// takes one bit per cycle, then take its result, then drop up to 9 leading
// zeros at one digit per cycle, then emit the digits; a signed negative value
// emits its '-' while the converter runs. Undefined type codes are taken and
// produce nothing.
module integer_to_ascii_formatter_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 req_type_i,
  input  logic [i2a_pkg::VAL_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_char_o,
  output logic                       last_char_o
);
  import i2a_pkg::*;

  i2a_state_e       state_q, state_d;
  req_type_e        type_q, type_d;
  logic [BCD_W-1:0] data_q, data_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_char_q, out_char_d;
  logic             out_last_q, out_last_d;

  i2a_cmd_t         cmd;
  i2a_sts_t         sts;
  logic [BCD_W-1:0] bcd;
  logic             out_free;
  logic             neg;
  logic             lead_zero;
  logic [7:0]       cur_char;

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign neg        = value_i[VAL_W-1];
  assign lead_zero  = (data_q[BCD_W-1 -: 4] == 4'd0) && (rem_q > REM_W'(1));

  assign cmd.start = in_valid_i && (state_q == ST_IDLE) &&
                     ((req_type_i == REQ_SIGNED) || (req_type_i == REQ_UNSIGNED));
  assign cmd.value = ((req_type_i == REQ_SIGNED) && neg) ? (~value_i + 1'b1) : value_i;

  i2a_dabble u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .bcd_o  (bcd)
  );

  always_comb begin
    unique case (type_q)
      REQ_HEX:                  cur_char = hex_char(data_q[BCD_W-1 -: 4]);
      REQ_BINARY:               cur_char = CHAR_ZERO + {7'b0, data_q[BCD_W-1]};
      REQ_SIGNED, REQ_UNSIGNED: cur_char = CHAR_ZERO + {4'b0, data_q[BCD_W-1 -: 4]};
      default:                  cur_char = data_q[BCD_W-1 -: 8];
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (req_type_i)
            REQ_LITERAL, REQ_HEX, REQ_BINARY: state_d = ST_EMIT;
            REQ_SIGNED:                       state_d = neg ? ST_SIGN : ST_CONV;
            REQ_UNSIGNED:                     state_d = ST_CONV;
            default:                          state_d = ST_IDLE;
          endcase
        end
      end
      ST_SIGN: begin
        if (out_free) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (!sts.busy) state_d = ST_TRIM;
      end
      ST_TRIM: begin
        if (!lead_zero) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && (rem_q == REM_W'(1))) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and output word
  always_comb begin
    type_d      = type_q;
    data_d      = data_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          type_d = req_type_e'(req_type_i);
          unique case (req_type_i)
            REQ_LITERAL: begin
              data_d = {value_i[7:0], {(BCD_W-8){1'b0}}};
              rem_d  = REM_W'(1);
            end
            REQ_HEX: begin
              data_d = {value_i, {(BCD_W-VAL_W){1'b0}}};
              rem_d  = REM_W'(VAL_W / 4);
            end
            REQ_BINARY: begin
              data_d = {value_i, {(BCD_W-VAL_W){1'b0}}};
              rem_d  = REM_W'(VAL_W);
            end
            default: ;
          endcase
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
        end
      end
      ST_CONV: begin
        if (!sts.busy) begin
          data_d = bcd;
          rem_d  = REM_W'(NUM_DEC_DIGITS);
        end
      end
      ST_TRIM: begin
        if (lead_zero) begin
          data_d = {data_q[BCD_W-5:0], 4'b0};
          rem_d  = rem_q - 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = cur_char;
          out_last_d  = (rem_q == REM_W'(1));
          rem_d       = rem_q - 1'b1;
          if (type_q == REQ_BINARY) begin
            data_d = {data_q[BCD_W-2:0], 1'b0};
          end else begin
            data_d = {data_q[BCD_W-5:0], 4'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q     <= type_d;
    data_q     <= data_d;
    rem_q      <= rem_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

endmodule

>>> hdl/i2a_checker.sv
// Port-level checker for the integer to ASCII formatter, bound to the top
`include "assert_macros.svh"

module i2a_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [2:0]                 req_type_i,
  input logic [i2a_pkg::VAL_W-1:0]  value_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [7:0]                 out_char_o,
  input logic                       last_char_o
);

  logic       in_acc;
  logic       def_req;
  logic       out_held;
  logic       idle_empty;
  logic [8:0] out_word;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign def_req    = (req_type_i <= i2a_pkg::REQ_BINARY);
  assign out_held   = out_valid_o && out_stall_i;
  assign idle_empty = !in_stall_o && !out_valid_o;
  assign out_word   = {out_char_o, last_char_o};

  // stalled output word holds
  `I2A_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o)

  `I2A_ASSERT_NEXT(a_out_data, clk_i, rst_ni, out_held, $stable(out_word))

  // a defined request keeps the input stalled in the next cycle
  `I2A_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_acc && def_req, in_stall_o)

  // an undefined request leaves the block idle
  `I2A_ASSERT_NEXT(a_undef_idle, clk_i, rst_ni, in_acc && !def_req, !in_stall_o)

  // an idle block with no word pending shows no word in the next cycle
  `I2A_ASSERT_NEXT(a_idle_no_word, clk_i, rst_ni, idle_empty, !out_valid_o)

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (.*);
